>>> hdl/rmlc_pkg.sv
`default_nettype none
package rmlc_pkg;

  // width of the modulus datapath, 8 to 32
  localparam int unsigned MOD_WIDTH = 32;
  // width of the input value and of the bit-serial multiplier operand
  localparam int unsigned VAL_WIDTH = 32;
  localparam int unsigned RES_WIDTH = 33;
  localparam int unsigned CFG_WIDTH = 32;
  localparam int unsigned CNT_WIDTH = $clog2(VAL_WIDTH);

  localparam logic [VAL_WIDTH-1:0] CHAR_BASE = VAL_WIDTH'(97);

  // configuration register indexes
  localparam logic [1:0] CFG_MODULUS     = 2'd0;
  localparam logic [1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] CFG_PRIVATE_EXP = 2'd2;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // status of one modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage
`default_nettype wire

>>> hdl/rmlc_modmul.sv
`default_nettype none
// bit-serial interleaved modular multiply, msb of a first: p = a * b mod n
// requires b < n and n >= 2; a may be any value
module rmlc_modmul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rmlc_pkg::VAL_WIDTH-1:0] a_i,
  input  wire logic [rmlc_pkg::MOD_WIDTH-1:0] b_i,
  input  wire logic [rmlc_pkg::MOD_WIDTH-1:0] n_i,
  output rmlc_pkg::mm_stat_t                 stat_o,
  output logic      [rmlc_pkg::MOD_WIDTH-1:0] p_o
);
  import rmlc_pkg::*;

  localparam int unsigned SW = MOD_WIDTH + 3;

  logic [VAL_WIDTH-1:0] a_q;
  logic [MOD_WIDTH-1:0] b_q, acc_q, acc_d;
  logic [CNT_WIDTH-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [SW-1:0]        sum, diff1, diff2;

  // 2*acc + bit*b stays below 3n, so one of three candidates is reduced
  always_comb begin
    sum   = (SW'(acc_q) << 1) + (a_q[VAL_WIDTH-1] ? SW'(b_q) : '0);
    diff1 = sum - SW'(n_i);
    diff2 = sum - (SW'(n_i) << 1);
    if (!diff2[SW-1]) begin
      acc_d = diff2[MOD_WIDTH-1:0];
    end else if (!diff1[SW-1]) begin
      acc_d = diff1[MOD_WIDTH-1:0];
    end else begin
      acc_d = sum[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_WIDTH'(1);
        if (cnt_q == CNT_WIDTH'(VAL_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= a_q << 1;
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule
`default_nettype wire

>>> hdl/rsa_modexp_letter_cipher.sv
`default_nettype none
// RSA letter cipher: one beat in, one beat out. An encrypt beat (tuser 0)
// carries a character code and returns (code - 97)^e mod n; a code below 97
// returns 0 with the bad-input flag set. A decrypt beat (tuser 1) returns
// (c^d mod n) + 97. A zero exponent gives 1 (plus 97 on decrypt) and a
// modulus of 0 or 1 gives 0 (plus 97 on decrypt) for any nonzero exponent.
// The power is computed by right-to-left square-and-multiply on two
// bit-serial modular multipliers that run side by side, one exponent bit
// per round; the first pass, on multiplier 0, reduces the base modulo n.
// Special cases skip the multipliers and reach the output register through
// ST_OUT. One operation is in flight at a time; the next beat is taken as
// soon as the result sits in the output register, even before it is drained.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i: 0
// modulus, 1 public exponent, 2 private exponent. The user must write it
// only while the block is idle; the block itself does not enforce this.
module rsa_modexp_letter_cipher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rmlc_pkg::CFG_WIDTH-1:0] cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // [31:0] input_value
  input  wire logic                          s_axis_tuser,  // [0] opcode
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [39:0]                   m_axis_tdata,  // [32:0] result_value, zero fill
  output logic                               m_axis_tuser   // [0] bad_input
);
  import rmlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CFG_WIDTH-1:0] modulus_q, pub_exp_q, priv_exp_q;

  // working registers of the exponentiation
  logic [CFG_WIDTH-1:0] exp_q;
  logic [MOD_WIDTH-1:0] acc_q, sq_q;
  logic                 addend_q;   // decrypt adds the character base
  logic [RES_WIDTH-1:0] res_q;
  logic                 res_bad_q;

  // output register
  logic                 out_valid_q;
  logic [RES_WIDTH-1:0] out_data_q;
  logic                 out_bad_q;

  logic [MOD_WIDTH-1:0] n_eff;
  logic                 in_beat;
  logic                 in_op;
  logic [VAL_WIDTH-1:0] in_val, in_base;
  logic [CFG_WIDTH-1:0] in_exp;

  // multiplier 0: base reduction, then acc * sq; multiplier 1: sq * sq
  logic                 mm0_start, mm1_start;
  logic [VAL_WIDTH-1:0] mm0_a;
  logic [MOD_WIDTH-1:0] mm0_b;
  mm_stat_t             mm0_stat, mm1_stat;
  logic [MOD_WIDTH-1:0] mm0_p, mm1_p;

  assign n_eff   = modulus_q[MOD_WIDTH-1:0];
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign in_op   = s_axis_tuser;
  assign in_val  = s_axis_tdata;
  assign in_base = (in_op == OP_DECRYPT) ? in_val : (in_val - CHAR_BASE);
  assign in_exp  = (in_op == OP_DECRYPT) ? priv_exp_q : pub_exp_q;

  assign s_axis_tready = (state_q == ST_IDLE);

  // reduce the base by multiplying with one, or start a square-and-multiply round
  logic start_reduce, start_round;
  assign start_reduce = in_beat && !((in_op == OP_ENCRYPT) && (in_val < CHAR_BASE))
                        && (in_exp != '0) && (n_eff > MOD_WIDTH'(1));
  assign start_round  = (state_q == ST_EXP) && (exp_q != '0);
  assign mm0_start    = start_reduce || start_round;
  assign mm1_start    = start_round;
  assign mm0_a        = start_reduce ? in_base : VAL_WIDTH'(acc_q);
  assign mm0_b        = start_reduce ? MOD_WIDTH'(1) : sq_q;

  rmlc_modmul u_mm0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm0_start),
    .a_i     (mm0_a),
    .b_i     (mm0_b),
    .n_i     (n_eff),
    .stat_o  (mm0_stat),
    .p_o     (mm0_p)
  );

  rmlc_modmul u_mm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm1_start),
    .a_i     (VAL_WIDTH'(sq_q)),
    .b_i     (sq_q),
    .n_i     (n_eff),
    .stat_o  (mm1_stat),
    .p_o     (mm1_p)
  );

  // configuration writes; index 3 is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= CFG_WIDTH'(3233);
      pub_exp_q  <= CFG_WIDTH'(17);
      priv_exp_q <= CFG_WIDTH'(2753);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS:     modulus_q  <= cfg_data_i;
        CFG_PUBLIC_EXP:  pub_exp_q  <= cfg_data_i;
        CFG_PRIVATE_EXP: priv_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_OUT the output register is either refilled or left untouched
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            addend_q  <= (in_op == OP_DECRYPT);
            exp_q     <= in_exp;
            res_bad_q <= 1'b0;
            if ((in_op == OP_ENCRYPT) && (in_val < CHAR_BASE)) begin
              res_q     <= '0;
              res_bad_q <= 1'b1;
              state_q   <= ST_OUT;
            end else if (in_exp == '0) begin
              // power of one, not reduced
              res_q   <= RES_WIDTH'(1) + ((in_op == OP_DECRYPT) ?
                         RES_WIDTH'(CHAR_BASE) : '0);
              state_q <= ST_OUT;
            end else if (n_eff <= MOD_WIDTH'(1)) begin
              res_q   <= (in_op == OP_DECRYPT) ? RES_WIDTH'(CHAR_BASE) : '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm0_stat.done) begin
            sq_q    <= mm0_p;
            acc_q   <= MOD_WIDTH'(1);
            state_q <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (exp_q == '0) begin
            res_q   <= RES_WIDTH'(acc_q) + (addend_q ? RES_WIDTH'(CHAR_BASE) : '0);
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // both multipliers start together and finish together
          if (mm1_stat.done) begin
            if (exp_q[0]) begin
              acc_q <= mm0_p;
            end
            sq_q    <= mm1_p;
            exp_q   <= exp_q >> 1;
            state_q <= ST_EXP;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            out_bad_q   <= res_bad_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};
  assign m_axis_tuser  = out_bad_q;

  // the paired multipliers stay in lockstep through a round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) && mm1_stat.done |-> mm0_stat.done)
    else $error("square and multiply units out of step");

  // every finished product of multiplier 0 is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm0_stat.done |-> (mm0_p < n_eff))
    else $error("modular product not below modulus");

  // a flagged encrypt beat always carries a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("bad input beat with nonzero result");

endmodule
`default_nettype wire
